// ===== rtl/core/bist_pkg.sv =====
// ----------------------------------------------------------------------------
// bist_pkg
// Shared types and constants for the bounded integer set table.
// ----------------------------------------------------------------------------
package bist_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int KEY_W    = 32;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_LIST   = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_INSERTED  = 3'd0,
		ST_DUPLICATE = 3'd1,
		ST_FULL      = 3'd2,
		ST_REMOVED   = 3'd3,
		ST_NOTFOUND  = 3'd4,
		ST_LISTED    = 3'd5,
		ST_EMPTY     = 3'd6
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_LIST,
		S_DONE
	} state_t;

endpackage

// ===== rtl/core/bounded_integer_set_table.sv =====
// ----------------------------------------------------------------------------
// bounded_integer_set_table
// Set of signed 32-bit keys in a single-port-read, single-port-write table,
// kept in insertion order; insert, remove with gap closing, and list.
// ----------------------------------------------------------------------------
//  channel | signals                                 | transfer when
//  --------+-----------------------------------------+----------------------
//  input   | in_valid in_ready op key                | in_valid & in_ready
//  output  | out_valid out_ready status key_out last | out_valid & out_ready
//
// insert/remove: scan reads one table entry per cycle (registered read), a
// remove then shifts later keys down, and the result is posted from the done
// state. list: one key per cycle while the output is not stalled.
// an unused op code is taken and gives no result.
// the output register lets a new item enter while a result still waits, so a
// stalled output holds up only a list or the next item's final result.
// reset clears the entry count; the table contents need no clearing.
// ----------------------------------------------------------------------------
module bounded_integer_set_table
	import bist_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [1:0]              op,
	input  logic signed [KEY_W-1:0] key,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [2:0]              status,
	output logic signed [KEY_W-1:0] key_out,
	output logic                    last
);

	logic [KEY_W-1:0] mem [CAPACITY];

	state_t           state_q, state_d;
	op_t              op_q;
	logic [KEY_W-1:0] key_q;
	logic [CNT_W-1:0] count_q, count_d;
	logic [CNT_W-1:0] rd_q, rd_d;
	status_t          res_q, res_d;

	logic             rvalid_s1, rvalid_d;
	logic [IDX_W-1:0] ridx_s1;
	logic [KEY_W-1:0] rdata_s1;

	logic             out_valid_q;
	status_t          status_q;
	logic [KEY_W-1:0] key_out_q;
	logic             last_q;

	logic             rd_en;
	logic [CNT_W-1:0] rd_addr;
	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	logic [KEY_W-1:0] mem_wdata;
	logic             out_load;
	status_t          ld_status;
	logic [KEY_W-1:0] ld_key;
	logic             ld_last;
	logic             emit;
	logic             match;
	logic             at_end;
	logic             out_free;
	logic [CNT_W-1:0] last_idx;

	// datapath control
	always_comb begin
		last_idx  = count_q - 1'b1;
		match     = rvalid_s1 && (rdata_s1 == key_q);
		at_end    = rvalid_s1 && (ridx_s1 == last_idx[IDX_W-1:0]);
		out_free  = !out_valid_q || out_ready;
		in_ready  = (state_q == S_IDLE);
		rd_en     = 1'b0;
		rd_addr   = rd_q;
		mem_we    = 1'b0;
		mem_waddr = ridx_s1 - 1'b1;
		mem_wdata = rdata_s1;
		out_load  = 1'b0;
		ld_status = res_q;
		ld_key    = key_q;
		ld_last   = 1'b1;
		emit      = 1'b0;
		rvalid_d  = 1'b0;
		unique case (state_q)
			S_SCAN: begin
				rd_en    = !match && !at_end && (rd_q < count_q);
				rvalid_d = rd_en;
			end
			S_SHIFT: begin
				rd_en    = rd_q < count_q;
				rvalid_d = rd_en;
				// entry i+1 moves down to i
				mem_we   = rvalid_s1;
			end
			S_LIST: begin
				emit      = rvalid_s1 && out_free;
				rd_en     = (rd_q != '0) && (!rvalid_s1 || emit);
				rd_addr   = rd_q - 1'b1;
				rvalid_d  = rd_en ? 1'b1 : (emit ? 1'b0 : rvalid_s1);
				out_load  = emit;
				ld_status = ST_LISTED;
				ld_key    = rdata_s1;
				ld_last   = (ridx_s1 == '0);
			end
			S_DONE: begin
				out_load = out_free;
				if (res_q == ST_EMPTY) begin
					ld_key = '0;
				end
				if (out_free && res_q == ST_INSERTED) begin
					mem_we    = 1'b1;
					mem_waddr = count_q[IDX_W-1:0];
					mem_wdata = key_q;
				end
			end
			default: begin
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		rd_d    = rd_q;
		res_d   = res_q;
		count_d = count_q;
		if (rd_en) begin
			rd_d = (state_q == S_LIST) ? rd_q - 1'b1 : rd_q + 1'b1;
		end
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					unique case (op)
						OP_INSERT, OP_REMOVE: begin
							if (count_q == '0) begin
								res_d   = (op == OP_INSERT) ? ST_INSERTED : ST_NOTFOUND;
								state_d = S_DONE;
							end else begin
								rd_d    = '0;
								state_d = S_SCAN;
							end
						end
						OP_LIST: begin
							if (count_q == '0) begin
								res_d   = ST_EMPTY;
								state_d = S_DONE;
							end else begin
								rd_d    = count_q;
								state_d = S_LIST;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_SCAN: begin
				if (match) begin
					if (op_q == OP_INSERT) begin
						res_d   = ST_DUPLICATE;
						state_d = S_DONE;
					end else if (at_end) begin
						res_d   = ST_REMOVED;
						state_d = S_DONE;
					end else begin
						rd_d    = CNT_W'(ridx_s1) + 1'b1;
						state_d = S_SHIFT;
					end
				end else if (at_end) begin
					if (op_q == OP_INSERT) begin
						res_d = (count_q == CNT_W'(CAPACITY)) ? ST_FULL : ST_INSERTED;
					end else begin
						res_d = ST_NOTFOUND;
					end
					state_d = S_DONE;
				end
			end
			S_SHIFT: begin
				if (at_end) begin
					res_d   = ST_REMOVED;
					state_d = S_DONE;
				end
			end
			S_LIST: begin
				if (emit && ridx_s1 == '0) begin
					state_d = S_IDLE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
					if (res_q == ST_INSERTED) begin
						count_d = count_q + 1'b1;
					end else if (res_q == ST_REMOVED) begin
						count_d = count_q - 1'b1;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rd_q        <= '0;
			res_q       <= ST_INSERTED;
			rvalid_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			rd_q        <= rd_d;
			res_q       <= res_d;
			rvalid_s1   <= rvalid_d;
			out_valid_q <= out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_q);
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q  <= op_t'(op);
			key_q <= key;
		end
		if (out_load) begin
			status_q  <= ld_status;
			key_out_q <= ld_key;
			last_q    <= ld_last;
		end
	end

	// key table; reads and writes never touch the same entry in one cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (rd_en) begin
			rdata_s1 <= mem[rd_addr[IDX_W-1:0]];
			ridx_s1  <= rd_addr[IDX_W-1:0];
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign key_out   = key_out_q;
	assign last      = last_q;

endmodule

// ===== rtl/core/bist_checker.sv =====
// ----------------------------------------------------------------------------
// bist_checker
// Port-level checks for the bounded integer set table, bound to the top level.
// ----------------------------------------------------------------------------
module bist_checker
	import bist_pkg::*;
(
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_ready,
	input logic [1:0]              op,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic [2:0]              status,
	input logic signed [KEY_W-1:0] key_out,
	input logic                    last
);

	// stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(key_out)
			&& $stable(last))
		else $error("result changed while stalled");

	// a real operation leaves the block busy in the cycle after it is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (op == OP_INSERT || op == OP_REMOVE || op == OP_LIST)
			|=> !in_ready)
		else $error("input taken while previous operation in flight");

	// insert, remove and a list of an empty set give a single result
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_LISTED |-> last)
		else $error("single result without last");

	// empty set reports a zero key
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_EMPTY |-> key_out == '0)
		else $error("empty status with nonzero key");

endmodule

bind bounded_integer_set_table bist_checker u_bist_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.op        (op),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.status    (status),
	.key_out   (key_out),
	.last      (last)
);
